@@ rtl/core/sbq_pkg.sv @@
package sbq_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 16;
   localparam int LENGTH_BITS_DEFAULT = 16;

   localparam int PENDING_BITS = 20;

   typedef enum logic [1:0] {
      OP_ENQUEUE = 2'd0,
      OP_CONSUME = 2'd1,
      OP_GATHER  = 2'd2
   } op_type;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_OVER = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ENQ,
      S_CPART,
      S_CREAD,
      S_CPOP,
      S_GPART,
      S_GREAD,
      S_GEMIT,
      S_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic enq;
      logic cons_part;
      logic rd;
      logic pop;
      logic gath_part;
      logic gath_ent;
      logic emit_done;
   } cmd_type;

   typedef struct packed {
      logic in_full;
      logic in_over;
      logic in_zero;
      logic part_valid;
      logic q_empty;
      logic cp_lt;
      logic cp_end;
      logic pop_end;
      logic gp_last;
      logic ge_last;
      logic out_free;
   } stat_type;

endpackage

@@ rtl/core/sbq_ctrl.sv @@
module sbq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [1:0]        req_operation,
   input  sbq_pkg::stat_type stat,
   output logic              req_stall,
   output sbq_pkg::cmd_type  cmd
);

   sbq_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sbq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sbq_pkg::S_IDLE: begin
            if (req_valid) begin
               if (req_operation == sbq_pkg::OP_ENQUEUE) begin
                  state_in = stat.in_full ? sbq_pkg::S_DONE : sbq_pkg::S_ENQ;
               end else if (req_operation == sbq_pkg::OP_CONSUME) begin
                  if (stat.in_over || stat.in_zero) state_in = sbq_pkg::S_DONE;
                  else if (stat.part_valid) state_in = sbq_pkg::S_CPART;
                  else state_in = sbq_pkg::S_CREAD;
               end else if (req_operation == sbq_pkg::OP_GATHER) begin
                  if (stat.in_zero) state_in = sbq_pkg::S_DONE;
                  else if (stat.part_valid) state_in = sbq_pkg::S_GPART;
                  else if (stat.q_empty) state_in = sbq_pkg::S_DONE;
                  else state_in = sbq_pkg::S_GREAD;
               end else begin
                  state_in = sbq_pkg::S_DONE;
               end
            end
         end
         sbq_pkg::S_ENQ: state_in = sbq_pkg::S_DONE;
         sbq_pkg::S_CPART: begin
            if (stat.cp_lt || stat.cp_end) state_in = sbq_pkg::S_DONE;
            else state_in = sbq_pkg::S_CREAD;
         end
         sbq_pkg::S_CREAD: state_in = sbq_pkg::S_CPOP;
         sbq_pkg::S_CPOP: begin
            state_in = stat.pop_end ? sbq_pkg::S_DONE : sbq_pkg::S_CREAD;
         end
         sbq_pkg::S_GPART: begin
            if (stat.out_free) begin
               state_in = stat.gp_last ? sbq_pkg::S_IDLE : sbq_pkg::S_GREAD;
            end
         end
         sbq_pkg::S_GREAD: state_in = sbq_pkg::S_GEMIT;
         sbq_pkg::S_GEMIT: begin
            if (stat.out_free) begin
               state_in = stat.ge_last ? sbq_pkg::S_IDLE : sbq_pkg::S_GREAD;
            end
         end
         sbq_pkg::S_DONE: begin
            if (stat.out_free) state_in = sbq_pkg::S_IDLE;
         end
         default: state_in = sbq_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = (state_ff != sbq_pkg::S_IDLE);
      unique case (state_ff)
         sbq_pkg::S_IDLE:  cmd.load = req_valid;
         sbq_pkg::S_ENQ:   cmd.enq = 1'b1;
         sbq_pkg::S_CPART: cmd.cons_part = 1'b1;
         sbq_pkg::S_CREAD: cmd.rd = 1'b1;
         sbq_pkg::S_CPOP:  cmd.pop = 1'b1;
         sbq_pkg::S_GPART: cmd.gath_part = stat.out_free;
         sbq_pkg::S_GREAD: cmd.rd = 1'b1;
         sbq_pkg::S_GEMIT: cmd.gath_ent = stat.out_free;
         sbq_pkg::S_DONE:  cmd.emit_done = stat.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

@@ rtl/core/sbq_dp.sv @@
module sbq_dp #(
   parameter int QUEUE_DEPTH = sbq_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int LENGTH_BITS = sbq_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [1:0]        req_operation,
   input  logic [15:0]       req_byte_count,
   input  logic [31:0]       req_buffer_handle,
   input  sbq_pkg::cmd_type  cmd,
   output sbq_pkg::stat_type stat,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output logic [31:0]       rsp_frag_handle,
   output logic [15:0]       rsp_frag_offset,
   output logic [15:0]       rsp_frag_length,
   output logic [19:0]       rsp_pending_total,
   output logic [1:0]        rsp_status,
   output logic              rsp_last
);

   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int LB = LENGTH_BITS;
   localparam int TB = LB + CW;
   localparam int PB = sbq_pkg::PENDING_BITS;
   localparam int TW = (TB > PB) ? TB : PB;

   logic [LB-1:0] mem_len [QUEUE_DEPTH];
   logic [31:0]   mem_handle [QUEUE_DEPTH];

   logic [IW-1:0] head_ff, tail_ff, idx_ff;
   logic [CW-1:0] count_ff, walk_ff;
   logic          part_valid_ff;
   logic [31:0]   part_handle_ff;
   logic [LB-1:0] part_len_ff, part_off_ff;
   logic [TB-1:0] total_ff, acc_ff;
   logic [1:0]    op_ff;
   logic [LB-1:0] len_ff;
   logic [31:0]   handle_ff;
   logic [1:0]    res_status_ff;
   logic [LB-1:0] rd_len_ff;
   logic [31:0]   rd_handle_ff;

   logic          rsp_valid_ff;
   logic [31:0]   frag_handle_ff;
   logic [15:0]   frag_offset_ff, frag_length_ff;
   logic [19:0]   pending_ff;
   logic [1:0]    status_ff;
   logic          last_ff;

   logic [LB-1:0] cnt;
   logic [LB-1:0] rest;
   logic [TB-1:0] acc_in;
   logic [LB-1:0] pop_len_in;
   logic          pop_fits;
   logic [IW-1:0] rd_addr;
   logic [TW-1:0] total_wide;
   logic [19:0]   pending_in;
   logic          out_free;
   logic          emit;

   function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] i);
      return (i == IW'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   assign cnt        = LB'(req_byte_count);
   assign rest       = part_len_ff - part_off_ff;
   assign acc_in     = acc_ff + TB'(rd_len_ff);
   assign pop_fits   = (rd_len_ff <= len_ff);
   assign pop_len_in = pop_fits ? len_ff - rd_len_ff : '0;
   assign rd_addr    = (op_ff == sbq_pkg::OP_GATHER) ? idx_ff : head_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign emit       = cmd.gath_part || cmd.gath_ent || cmd.emit_done;

   assign total_wide = TW'(total_ff);
   assign pending_in = (total_wide > TW'(20'hFFFFF)) ? 20'hFFFFF : 20'(total_wide);

   always_comb begin
      stat = '0;
      stat.in_full    = (CW'(count_ff + CW'(part_valid_ff)) >= CW'(QUEUE_DEPTH));
      stat.in_over    = (TB'(cnt) > total_ff);
      stat.in_zero    = (cnt == '0);
      stat.part_valid = part_valid_ff;
      stat.q_empty    = (count_ff == '0);
      stat.cp_lt      = (len_ff < rest);
      stat.cp_end     = (len_ff == rest) || (count_ff == '0);
      stat.pop_end    = (pop_len_in == '0) || (count_ff == CW'(1));
      stat.gp_last    = (rest >= len_ff) || (count_ff == '0);
      stat.ge_last    = (acc_in >= TB'(len_ff)) || (CW'(walk_ff + 1'b1) == count_ff);
      stat.out_free   = out_free;
   end

   always_ff @(posedge clock) begin
      if (cmd.enq) begin
         mem_len[tail_ff]    <= len_ff;
         mem_handle[tail_ff] <= handle_ff;
      end
      if (cmd.rd) begin
         rd_len_ff    <= mem_len[rd_addr];
         rd_handle_ff <= mem_handle[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff        <= '0;
         tail_ff        <= '0;
         count_ff       <= '0;
         part_valid_ff  <= 1'b0;
         part_handle_ff <= '0;
         part_len_ff    <= '0;
         part_off_ff    <= '0;
         total_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (cmd.enq) begin
            tail_ff  <= wrap_inc(tail_ff);
            count_ff <= count_ff + 1'b1;
            total_ff <= total_ff + TB'(len_ff);
         end
         if (cmd.cons_part) begin
            if (len_ff < rest) begin
               part_off_ff <= part_off_ff + len_ff;
               total_ff    <= total_ff - TB'(len_ff);
            end else begin
               total_ff       <= total_ff - TB'(rest);
               part_valid_ff  <= 1'b0;
               part_handle_ff <= '0;
               part_len_ff    <= '0;
               part_off_ff    <= '0;
            end
         end
         if (cmd.pop) begin
            head_ff  <= wrap_inc(head_ff);
            count_ff <= count_ff - 1'b1;
            if (pop_fits) begin
               total_ff <= total_ff - TB'(rd_len_ff);
            end else begin
               part_valid_ff  <= 1'b1;
               part_handle_ff <= rd_handle_ff;
               part_len_ff    <= rd_len_ff;
               part_off_ff    <= len_ff;
               total_ff       <= total_ff - TB'(len_ff);
            end
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_operation;
         len_ff    <= cnt;
         handle_ff <= req_buffer_handle;
         acc_ff    <= '0;
         walk_ff   <= '0;
         idx_ff    <= head_ff;
         if (req_operation == sbq_pkg::OP_ENQUEUE && stat.in_full) begin
            res_status_ff <= sbq_pkg::STATUS_FULL;
         end else if (req_operation == sbq_pkg::OP_CONSUME && stat.in_over) begin
            res_status_ff <= sbq_pkg::STATUS_OVER;
         end else begin
            res_status_ff <= sbq_pkg::STATUS_OK;
         end
      end
      if (cmd.cons_part) begin
         len_ff <= (len_ff < rest) ? '0 : len_ff - rest;
      end
      if (cmd.pop) begin
         len_ff <= pop_len_in;
      end
      if (cmd.gath_part) begin
         acc_ff <= TB'(rest);
      end
      if (cmd.gath_ent) begin
         acc_ff  <= acc_in;
         walk_ff <= walk_ff + 1'b1;
         idx_ff  <= wrap_inc(idx_ff);
      end
      if (emit) begin
         pending_ff <= pending_in;
         status_ff  <= cmd.emit_done ? res_status_ff : sbq_pkg::STATUS_OK;
         priority if (cmd.gath_part) begin
            frag_handle_ff <= part_handle_ff;
            frag_offset_ff <= 16'(part_off_ff);
            frag_length_ff <= 16'(rest);
            last_ff        <= stat.gp_last;
         end else if (cmd.gath_ent) begin
            frag_handle_ff <= rd_handle_ff;
            frag_offset_ff <= '0;
            frag_length_ff <= 16'(rd_len_ff);
            last_ff        <= stat.ge_last;
         end else begin
            frag_handle_ff <= '0;
            frag_offset_ff <= '0;
            frag_length_ff <= '0;
            last_ff        <= 1'b1;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frag_handle   = frag_handle_ff;
   assign rsp_frag_offset   = frag_offset_ff;
   assign rsp_frag_length   = frag_length_ff;
   assign rsp_pending_total = pending_ff;
   assign rsp_status        = status_ff;
   assign rsp_last          = last_ff;

   // occupancy including the partial packet never passes the depth
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      (CW+1)'(count_ff) + (CW+1)'(part_valid_ff) <= (CW+1)'(QUEUE_DEPTH))
      else $error("queue occupancy above depth");

   a_partial_off: assert property (@(posedge clock) disable iff (reset)
      part_valid_ff |-> (part_off_ff < part_len_ff))
      else $error("partial offset not below length");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result written over a waiting transaction");

   a_one_emit: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.gath_part, cmd.gath_ent, cmd.emit_done}))
      else $error("more than one result source");

endmodule

@@ rtl/core/send_byte_queue_partial_dequeue.sv @@
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_stall  | operation, byte_count, buffer_handle
// rsp     | out       | rsp_valid/rsp_stall  | frag_*, pending_total, status, last
// one request transaction at a time; enqueue stores then emits its result, no store when full
// consume does one memory read and one update per popped descriptor, after any partial step
// gather emits the partial rest, then reads and emits queued fragments; an empty result if none
// reset is synchronous and clears pointers, counts, partial packet and total
// rsp_stall holds the result register; a new request is taken once the prior one is done
module send_byte_queue_partial_dequeue #(
   parameter int QUEUE_DEPTH = sbq_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int LENGTH_BITS = sbq_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [15:0] req_byte_count,
   input  logic [31:0] req_buffer_handle,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_frag_handle,
   output logic [15:0] rsp_frag_offset,
   output logic [15:0] rsp_frag_length,
   output logic [19:0] rsp_pending_total,
   output logic [1:0]  rsp_status,
   output logic        rsp_last
);

   sbq_pkg::cmd_type  cmd;
   sbq_pkg::stat_type stat;

   sbq_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .stat          (stat),
      .req_stall     (req_stall),
      .cmd           (cmd)
   );

   sbq_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_operation     (req_operation),
      .req_byte_count    (req_byte_count),
      .req_buffer_handle (req_buffer_handle),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_frag_handle   (rsp_frag_handle),
      .rsp_frag_offset   (rsp_frag_offset),
      .rsp_frag_length   (rsp_frag_length),
      .rsp_pending_total (rsp_pending_total),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last)
   );

endmodule

@@ tb/sbq_checker.sv @@
module sbq_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [15:0] req_byte_count,
   input  logic [31:0] req_buffer_handle,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_frag_handle,
   input  logic [15:0] rsp_frag_offset,
   input  logic [15:0] rsp_frag_length,
   input  logic [19:0] rsp_pending_total,
   input  logic [1:0]  rsp_status,
   input  logic        rsp_last,
   output int          fail_count,
   output int          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = sbq_pkg::QUEUE_DEPTH_DEFAULT;

   typedef struct packed {
      logic [31:0] handle;
      logic [15:0] offset;
      logic [15:0] length;
      logic [19:0] pending;
      logic [1:0]  status;
      logic        last;
   } frag_type;

   frag_type    expected_frags[$];
   logic [15:0] desc_length [DEPTH];
   logic [31:0] desc_handle [DEPTH];
   logic [3:0]  head_ptr;
   logic [3:0]  tail_ptr;
   int          desc_count;
   logic        part_valid;
   logic [31:0] part_handle;
   logic [15:0] part_length;
   logic [15:0] part_offset;
   logic [20:0] queued_bytes;

   initial begin
      fail_count = 0;
      outstanding = 0;
   end

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("%0t: %s got %0h expected %0h", $time, what, got, want);
      fail_count++;
   endtask

   function automatic frag_type make_frag(input logic [31:0] h, input logic [15:0] off,
                                          input logic [15:0] len, input logic [1:0] st,
                                          input logic lst);
      frag_type f;
      f.handle  = h;
      f.offset  = off;
      f.length  = len;
      f.pending = (queued_bytes > 21'hFFFFF) ? 20'hFFFFF : queued_bytes[19:0];
      f.status  = st;
      f.last    = lst;
      return f;
   endfunction

   task automatic run_enqueue(input logic [15:0] len, input logic [31:0] h);
      logic [1:0] st;
      st = sbq_pkg::STATUS_OK;
      if (desc_count + part_valid >= DEPTH) begin
         st = sbq_pkg::STATUS_FULL;
      end else begin
         desc_length[tail_ptr] = len;
         desc_handle[tail_ptr] = h;
         tail_ptr++;
         desc_count++;
         queued_bytes += len;
      end
      expected_frags.push_back(make_frag(0, 0, 0, st, 1'b1));
   endtask

   task automatic run_consume(input logic [15:0] sent);
      logic [1:0]  st;
      logic [15:0] rest;
      logic [15:0] len;
      int          left;
      st = sbq_pkg::STATUS_OK;
      left = sent;
      if (sent > queued_bytes) begin
         st = sbq_pkg::STATUS_OVER;
      end else if (sent != 0) begin
         if (part_valid) begin
            rest = part_length - part_offset;
            if (left < rest) begin
               part_offset += left;
               queued_bytes -= left;
               left = 0;
            end else begin
               queued_bytes -= rest;
               left -= rest;
               part_valid = 0;
               part_handle = 0;
               part_length = 0;
               part_offset = 0;
            end
         end
         while (left > 0 && desc_count > 0) begin
            len = desc_length[head_ptr];
            if (len <= left) begin
               queued_bytes -= len;
               left -= len;
            end else begin
               part_valid = 1;
               part_handle = desc_handle[head_ptr];
               part_length = len;
               part_offset = left;
               queued_bytes -= left;
               left = 0;
            end
            head_ptr++;
            desc_count--;
         end
      end
      expected_frags.push_back(make_frag(0, 0, 0, st, 1'b1));
   endtask

   task automatic run_gather(input logic [15:0] allowed);
      frag_type    list[$];
      int          sum;
      logic [3:0]  idx;
      sum = 0;
      idx = head_ptr;
      if (allowed != 0) begin
         if (part_valid) begin
            list.push_back(make_frag(part_handle, part_offset, part_length - part_offset,
                                     sbq_pkg::STATUS_OK, 1'b0));
            sum += part_length - part_offset;
         end
         for (int i = 0; i < desc_count && sum < allowed; i++) begin
            list.push_back(make_frag(desc_handle[idx], 0, desc_length[idx],
                                     sbq_pkg::STATUS_OK, 1'b0));
            sum += desc_length[idx];
            idx++;
         end
      end
      if (list.size() == 0) begin
         list.push_back(make_frag(0, 0, 0, sbq_pkg::STATUS_OK, 1'b0));
      end
      list[list.size() - 1].last = 1'b1;
      foreach (list[i]) begin
         expected_frags.push_back(list[i]);
      end
   endtask

   always @(posedge clock) begin
      frag_type want;
      if (reset) begin
         head_ptr = 0;
         tail_ptr = 0;
         desc_count = 0;
         part_valid = 0;
         part_handle = 0;
         part_length = 0;
         part_offset = 0;
         queued_bytes = 0;
         expected_frags.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_frags.size() == 0) begin
               report("result with nothing expected, handle", rsp_frag_handle, 0);
            end else begin
               want = expected_frags.pop_front();
               if (rsp_frag_handle !== want.handle)
                  report("frag_handle", rsp_frag_handle, want.handle);
               if (rsp_frag_offset !== want.offset)
                  report("frag_offset", rsp_frag_offset, want.offset);
               if (rsp_frag_length !== want.length)
                  report("frag_length", rsp_frag_length, want.length);
               if (rsp_pending_total !== want.pending)
                  report("pending_total", rsp_pending_total, want.pending);
               if (rsp_status !== want.status)
                  report("status", rsp_status, want.status);
               if (rsp_last !== want.last)
                  report("last", rsp_last, want.last);
            end
         end
         if (req_valid && !req_stall) begin
            case (req_operation)
               sbq_pkg::OP_ENQUEUE: run_enqueue(req_byte_count, req_buffer_handle);
               sbq_pkg::OP_CONSUME: run_consume(req_byte_count);
               sbq_pkg::OP_GATHER:  run_gather(req_byte_count);
               default: expected_frags.push_back(make_frag(0, 0, 0, sbq_pkg::STATUS_OK, 1'b1));
            endcase
         end
      end
      outstanding = expected_frags.size();
   end

endmodule

@@ tb/testbench.sv @@
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic        clock = 0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_operation;
   logic [15:0] req_byte_count;
   logic [31:0] req_buffer_handle;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_frag_handle;
   logic [15:0] rsp_frag_offset;
   logic [15:0] rsp_frag_length;
   logic [19:0] rsp_pending_total;
   logic [1:0]  rsp_status;
   logic        rsp_last;
   int          fail_count;
   int          outstanding;
   bit          quiet = 0;
   bit          long_hold_req = 0;

   always #10 clock = ~clock;

   send_byte_queue_partial_dequeue uut (.*);

   sbq_checker checker_i (.*);

   initial begin
      #5ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // receiver side
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
            long_hold_req = 0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_item(input logic [1:0] op, input logic [15:0] cnt,
                            input logic [31:0] h);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_byte_count    <= cnt;
      req_buffer_handle <= h;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic [15:0] pick_count();
      case ($urandom_range(0, 9))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         2:       return 16'($urandom);
         default: return 16'($urandom_range(1, 1500));
      endcase
   endfunction

   initial begin
      int          mode;
      int          dice;
      logic [1:0]  op;
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_operation     <= sbq_pkg::OP_ENQUEUE;
      req_byte_count    <= 0;
      req_buffer_handle <= 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners
      send_item(sbq_pkg::OP_GATHER, 16'd100, 0);
      send_item(sbq_pkg::OP_CONSUME, 16'd0, 0);
      send_item(sbq_pkg::OP_CONSUME, 16'd1, 0);
      send_item(OP_UNUSED, 16'hFFFF, 32'hFFFFFFFF);
      send_item(sbq_pkg::OP_ENQUEUE, 16'd0, 32'h0);
      send_item(sbq_pkg::OP_ENQUEUE, 16'hFFFF, 32'hFFFFFFFF);
      send_item(sbq_pkg::OP_ENQUEUE, 16'd10, 32'h5A5A_A5A5);
      send_item(sbq_pkg::OP_GATHER, 16'd0, 0);
      send_item(sbq_pkg::OP_GATHER, 16'hFFFF, 0);
      send_item(sbq_pkg::OP_GATHER, 16'd1, 0);
      send_item(sbq_pkg::OP_CONSUME, 16'd5, 0);
      send_item(sbq_pkg::OP_GATHER, 16'd3, 0);
      send_item(sbq_pkg::OP_CONSUME, 16'hFFFF, 0);
      send_item(sbq_pkg::OP_GATHER, 16'hFFFF, 0);
      send_item(sbq_pkg::OP_CONSUME, 16'd5, 0);
      send_item(sbq_pkg::OP_CONSUME, 16'd1, 0);
      send_item(sbq_pkg::OP_GATHER, 16'hFFFF, 0);

      mode = 0;
      for (int n = 0; n < 150; n++) begin
         if (n % 20 == 0) mode = $urandom_range(0, 2);
         if (n == 60) long_hold_req = 1;
         if (n == 100) begin
            req_valid <= 1'b0;
            @(posedge clock);
            wait (outstanding == 0);
            @(posedge clock);
         end
         if (n == 120) quiet = 1;
         dice = $urandom_range(0, 99);
         case (mode)
            1:       op = dice < 80 ? sbq_pkg::OP_ENQUEUE :
                          (dice < 90 ? sbq_pkg::OP_GATHER : sbq_pkg::OP_CONSUME);
            2:       op = dice < 55 ? sbq_pkg::OP_CONSUME :
                          (dice < 90 ? sbq_pkg::OP_GATHER : sbq_pkg::OP_ENQUEUE);
            default: op = dice < 40 ? sbq_pkg::OP_ENQUEUE :
                          (dice < 70 ? sbq_pkg::OP_CONSUME :
                          (dice < 97 ? sbq_pkg::OP_GATHER : OP_UNUSED));
         endcase
         send_item(op, pick_count(), $urandom);
      end
      req_valid <= 1'b0;
      @(posedge clock);
      wait (outstanding == 0);
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ send_byte_queue_partial_dequeue.f @@
rtl/core/sbq_pkg.sv
rtl/core/sbq_ctrl.sv
rtl/core/sbq_dp.sv
rtl/core/send_byte_queue_partial_dequeue.sv
tb/sbq_checker.sv
tb/testbench.sv
